// ===== src/lns_pkg.sv =====
package lns_pkg;

  localparam int unsigned RefrBits = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    CfgFireThreshold  = 3'd0,
    CfgLeakShift      = 3'd1,
    CfgAfterSpike     = 3'd2,
    CfgRestingLevel   = 3'd3,
    CfgRefractoryTick = 3'd4
  } cfg_idx_e;

  localparam logic signed [15:0] ThresholdRst = 16'sd1024;
  localparam logic [4:0]         LeakShiftRst = 5'd4;
  localparam logic signed [15:0] AfterSpkRst  = 16'sd0;
  localparam logic signed [15:0] RestingRst   = 16'sd0;
  localparam logic [7:0]         RefrTicksRst = 8'd2;

  localparam logic signed [15:0] PotMax = 16'sh7fff;
  localparam logic signed [15:0] PotMin = -16'sh8000;

  typedef struct packed {
    logic signed [15:0] fire_threshold;
    logic [4:0]         leak_shift;
    logic signed [15:0] after_spike_level;
    logic signed [15:0] resting_level;
    logic [7:0]         refractory_ticks;
  } cfg_t;

  typedef struct packed {
    logic               spike;
    logic signed [15:0] potential;
    logic [7:0]         refractory_left;
  } res_t;

endpackage

// ===== src/lif_neuron_step_unit.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: inj_current, tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: spike, potential, refractory_left
// cfg       in   cfg_we_i                      cfg_addr_i, cfg_data_i
//
// one time step per clock while the output is not stalled; a beat is registered
// at the input, computed from the input register and held in the output
// register once the output has room.
// the neuron state updates in the same cycle the result is registered, which
// lets the next beat use it right away.
// reset returns config registers to defaults, potential to rest, count to zero.
// a stalled output keeps one result and one pending beat; s_axis_tready drops
// only when both are full and m_axis_tready is low.
module lif_neuron_step_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // [31:0] inj_current
  input  logic                         s_axis_tuser,  // [0] mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] spike, [16:1] potential, [24:17] refractory_left, [31:25] zero
  output logic [31:0]                  m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [lns_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [lns_pkg::CfgDataW-1:0] cfg_data_i
);
  import lns_pkg::*;

  cfg_t cfg;
  res_t res;

  logic               in_valid_q;
  logic               in_mode_q;
  logic signed [31:0] in_cur_q;
  logic               out_valid_q;
  res_t               out_res_q;
  logic               adv;
  logic               in_take;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  lns_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lns_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .adv_i     (adv),
    .mode_i    (in_mode_q),
    .current_i (in_cur_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= s_axis_tuser;
      in_cur_q  <= s_axis_tdata;
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.refractory_left, out_res_q.potential,
                          out_res_q.spike};

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_cur_q) && $stable(in_mode_q))
    else $error("pending beat lost while the output was stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_res_q))
    else $error("held result overwritten while stalled");

  a_adv_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> in_valid_q && (!out_valid_q || m_axis_tready))
    else $error("core advanced without room or item");

endmodule

// ===== src/lns_cfg_regs.sv =====
module lns_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lns_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [lns_pkg::CfgDataW-1:0] cfg_data_i,
  output lns_pkg::cfg_t                cfg_o
);
  import lns_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fire_threshold    <= ThresholdRst;
      cfg_q.leak_shift        <= LeakShiftRst;
      cfg_q.after_spike_level <= AfterSpkRst;
      cfg_q.resting_level     <= RestingRst;
      cfg_q.refractory_ticks  <= RefrTicksRst;
    end else if (cfg_we_i) begin
      // writes to unused indexes are dropped
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgFireThreshold:  cfg_q.fire_threshold    <= cfg_data_i;
        CfgLeakShift:      cfg_q.leak_shift        <= cfg_data_i[4:0];
        CfgAfterSpike:     cfg_q.after_spike_level <= cfg_data_i;
        CfgRestingLevel:   cfg_q.resting_level     <= cfg_data_i;
        CfgRefractoryTick: cfg_q.refractory_ticks  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lns_core.sv =====
module lns_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lns_pkg::cfg_t       cfg_i,
  input  logic                adv_i,
  input  logic                mode_i,
  input  logic signed [31:0]  current_i,
  output lns_pkg::res_t       res_o
);
  import lns_pkg::*;

  logic signed [15:0]  mem_q, mem_d;
  logic [RefrBits-1:0] cnt_q, cnt_d;
  logic                spike;

  logic signed [32:0] sum;
  logic signed [15:0] sat;
  logic signed [16:0] delta;
  logic signed [16:0] shifted;
  logic signed [16:0] leak;
  logic signed [16:0] leaked;

  always_comb begin
    sum = {{17{mem_q[15]}}, mem_q} + {current_i[31], current_i};
    priority if (sum > 33'(PotMax)) begin
      sat = PotMax;
    end else if (sum < 33'(PotMin)) begin
      sat = PotMin;
    end else begin
      sat = sum[15:0];
    end

    // arithmetic shift floors negative distances
    delta   = {sat[15], sat} - {cfg_i.resting_level[15], cfg_i.resting_level};
    shifted = delta >>> cfg_i.leak_shift;
    leak    = ((delta != '0) && (shifted == '0)) ? 17'sd1 : shifted;
    // result lies between sat and rest, so 16 bits hold it
    leaked  = {sat[15], sat} - leak;
  end

  always_comb begin
    spike = 1'b0;
    mem_d = mem_q;
    cnt_d = cnt_q;
    priority if (mode_i) begin
      mem_d = cfg_i.resting_level;
      cnt_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end else if ($signed(leaked[15:0]) >= cfg_i.fire_threshold) begin
      spike = 1'b1;
      mem_d = cfg_i.after_spike_level;
      cnt_d = RefrBits'(cfg_i.refractory_ticks);
    end else begin
      mem_d = leaked[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= RestingRst;
      cnt_q <= '0;
    end else if (adv_i) begin
      mem_q <= mem_d;
      cnt_q <= cnt_d;
    end
  end

  assign res_o.spike           = spike;
  assign res_o.potential       = mem_d;
  assign res_o.refractory_left = 8'(cnt_d);

  a_clear_restores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && mode_i |=> (mem_q == $past(cfg_i.resting_level)) && (cnt_q == '0))
    else $error("clear did not restore resting state");

  a_refr_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !mode_i && (cnt_q != '0) |=>
      (cnt_q == RefrBits'($past(cnt_q) - 1'b1)) && (mem_q == $past(mem_q)))
    else $error("refractory step changed potential or miscounted");

  a_spike_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && spike |=> (cnt_q == RefrBits'($past(cfg_i.refractory_ticks)))
      && (mem_q == $past(cfg_i.after_spike_level)))
    else $error("spike did not load refractory period and after-spike level");

endmodule
